// ===== src/v2sl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package v2sl_pkg;

    localparam int DW = 32;
    localparam int PW = 2 * DW;

    typedef struct packed {
        logic signed [DW-1:0] vec_x;
        logic signed [DW-1:0] vec_y;
        logic signed [DW-1:0] target_length;
    } t_in;

    typedef struct packed {
        logic        [DW-1:0] length;
        logic signed [DW-1:0] scaled_x;
        logic signed [DW-1:0] scaled_y;
        logic                 zero_vector;
    } t_out;

    typedef struct packed {
        logic [DW-1:0] xm;
        logic [DW-1:0] ym;
        logic [DW-1:0] tm;
        logic          xneg;
        logic          yneg;
        logic          tneg;
        logic [PW-1:0] axx;
        logic [PW-1:0] ayy;
        logic [PW-1:0] axt;
        logic [PW-1:0] ayt;
    } t_mul_st;

    typedef struct packed {
        logic [PW-1:0] rem;
        logic [DW-1:0] root;
        logic [PW-1:0] pxt;
        logic [PW-1:0] pyt;
        logic          nx;
        logic          ny;
    } t_sqrt_st;

    typedef struct packed {
        logic [DW-1:0] len;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
        logic [PW-1:0] qx;
        logic [PW-1:0] qy;
        logic          nx;
        logic          ny;
    } t_div_st;

endpackage
`default_nettype wire

// ===== src/vector2_scale_to_length.sv =====
// Pipeline: DW shift-add cells for the products, DW square root cells,
// 2*DW restoring divider cells and one output register.
// Throughput: one transaction per cycle; the whole cell chain advances together
// and holds while a waiting result is stalled.
// Reset: synchronous active-low reset clears all valid flags; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module vector2_scale_to_length (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  v2sl_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output v2sl_pkg::t_out    o_out_data
);
    import v2sl_pkg::*;

    logic     en;
    t_mul_st  mul_d [DW+1];
    logic     mul_v [DW+1];
    t_sqrt_st sq_d  [DW+1];
    logic     sq_v  [DW+1];
    t_div_st  dv_d  [PW+1];
    logic     dv_v  [PW+1];
    t_div_st  fin;
    t_out     n_out;
    t_out     r_out;
    logic     r_out_valid;

    localparam logic [PW-1:0] SAT_NEG = PW'(1) << (DW - 1);
    localparam logic [PW-1:0] SAT_POS = SAT_NEG - PW'(1);

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    always_comb begin
        mul_d[0]      = '0;
        mul_d[0].xneg = i_in_data.vec_x[DW-1];
        mul_d[0].yneg = i_in_data.vec_y[DW-1];
        mul_d[0].tneg = i_in_data.target_length[DW-1];
        mul_d[0].xm   = i_in_data.vec_x[DW-1] ? DW'(-i_in_data.vec_x) : i_in_data.vec_x;
        mul_d[0].ym   = i_in_data.vec_y[DW-1] ? DW'(-i_in_data.vec_y) : i_in_data.vec_y;
        mul_d[0].tm   = i_in_data.target_length[DW-1] ?
                        DW'(-i_in_data.target_length) : i_in_data.target_length;
    end
    assign mul_v[0] = i_in_valid;

    for (genvar i = 0; i < DW; i++) begin : g_mul
        v2sl_mul_cell #(.BIT(i)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (mul_v[i]),
            .i_data  (mul_d[i]),
            .o_valid (mul_v[i+1]),
            .o_data  (mul_d[i+1])
        );
    end

    always_comb begin
        sq_d[0].rem  = mul_d[DW].axx + mul_d[DW].ayy;
        sq_d[0].root = '0;
        sq_d[0].pxt  = mul_d[DW].axt;
        sq_d[0].pyt  = mul_d[DW].ayt;
        sq_d[0].nx   = mul_d[DW].xneg ^ mul_d[DW].tneg;
        sq_d[0].ny   = mul_d[DW].yneg ^ mul_d[DW].tneg;
    end
    assign sq_v[0] = mul_v[DW];

    for (genvar k = 0; k < DW; k++) begin : g_sqrt
        v2sl_sqrt_cell #(.BIT(DW - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[k]),
            .i_data  (sq_d[k]),
            .o_valid (sq_v[k+1]),
            .o_data  (sq_d[k+1])
        );
    end

    always_comb begin
        dv_d[0]     = '0;
        dv_d[0].len = sq_d[DW].root;
        dv_d[0].px  = sq_d[DW].pxt;
        dv_d[0].py  = sq_d[DW].pyt;
        dv_d[0].nx  = sq_d[DW].nx;
        dv_d[0].ny  = sq_d[DW].ny;
    end
    assign dv_v[0] = sq_v[DW];

    for (genvar j = 0; j < PW; j++) begin : g_div
        v2sl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[j]),
            .i_data  (dv_d[j]),
            .o_valid (dv_v[j+1]),
            .o_data  (dv_d[j+1])
        );
    end

    assign fin = dv_d[PW];

    always_comb begin
        n_out             = '0;
        n_out.length      = fin.len;
        n_out.zero_vector = (fin.len == '0);
        if (fin.len != '0) begin
            if (fin.nx) begin
                n_out.scaled_x = (fin.qx > SAT_NEG) ? DW'(SAT_NEG) : DW'(-fin.qx);
            end else begin
                n_out.scaled_x = (fin.qx > SAT_POS) ? DW'(SAT_POS) : fin.qx[DW-1:0];
            end
            if (fin.ny) begin
                n_out.scaled_y = (fin.qy > SAT_NEG) ? DW'(SAT_NEG) : DW'(-fin.qy);
            end else begin
                n_out.scaled_y = (fin.qy > SAT_POS) ? DW'(SAT_POS) : fin.qy[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v[PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_vector |->
            o_out_data.scaled_x == '0 && o_out_data.scaled_y == '0)
        else $error("zero vector with nonzero scaled output");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.zero_vector == (o_out_data.length == '0))
        else $error("zero flag disagrees with length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while the result is stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

// ===== src/v2sl_mul_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module v2sl_mul_cell #(
    parameter int BIT = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  v2sl_pkg::t_mul_st     i_data,
    output logic                  o_valid,
    output v2sl_pkg::t_mul_st     o_data
);
    import v2sl_pkg::*;

    logic    r_valid;
    t_mul_st r_data;
    t_mul_st n_data;

    always_comb begin
        n_data = i_data;
        if (i_data.xm[BIT]) begin
            n_data.axx = i_data.axx + (PW'(i_data.xm) << BIT);
        end
        if (i_data.ym[BIT]) begin
            n_data.ayy = i_data.ayy + (PW'(i_data.ym) << BIT);
        end
        if (i_data.tm[BIT]) begin
            n_data.axt = i_data.axt + (PW'(i_data.xm) << BIT);
            n_data.ayt = i_data.ayt + (PW'(i_data.ym) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ===== src/v2sl_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module v2sl_sqrt_cell #(
    parameter int BIT = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  v2sl_pkg::t_sqrt_st    i_data,
    output logic                  o_valid,
    output v2sl_pkg::t_sqrt_st    o_data
);
    import v2sl_pkg::*;

    logic          r_valid;
    t_sqrt_st      r_data;
    t_sqrt_st      n_data;
    logic [PW-1:0] trial;

    always_comb begin
        trial  = (PW'(i_data.root) << (BIT + 1)) | (PW'(1) << (2 * BIT));
        n_data = i_data;
        if (i_data.rem >= trial) begin
            n_data.rem  = i_data.rem - trial;
            n_data.root = i_data.root | (DW'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ===== src/v2sl_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module v2sl_div_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  v2sl_pkg::t_div_st     i_data,
    output logic                  o_valid,
    output v2sl_pkg::t_div_st     o_data
);
    import v2sl_pkg::*;

    logic        r_valid;
    t_div_st     r_data;
    t_div_st     n_data;
    logic [DW:0] shx;
    logic [DW:0] shy;
    logic [DW:0] dv;
    logic        gex;
    logic        gey;

    always_comb begin
        shx    = {i_data.rx, i_data.px[PW-1]};
        shy    = {i_data.ry, i_data.py[PW-1]};
        dv     = {1'b0, i_data.len};
        gex    = shx >= dv;
        gey    = shy >= dv;
        n_data = i_data;
        n_data.px = {i_data.px[PW-2:0], 1'b0};
        n_data.py = {i_data.py[PW-2:0], 1'b0};
        n_data.qx = {i_data.qx[PW-2:0], gex};
        n_data.qy = {i_data.qy[PW-2:0], gey};
        n_data.rx = gex ? DW'(shx - dv) : shx[DW-1:0];
        n_data.ry = gey ? DW'(shy - dv) : shy[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire
